[sv/swmf_pkg.sv]
// ============================================================================
// swmf_pkg: shared types and constants of the sliding window median filter
// Sizes of the line store, the window and the rank-select pipeline.
// ============================================================================
`default_nettype none

package swmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int LINES      = 2 * MAX_RADIUS;
    localparam int SIDE       = 2 * MAX_RADIUS + 1;
    localparam int WIN        = SIDE * SIDE;
    localparam int MID        = WIN / 2;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(LINES);
    localparam int RANK_W     = $clog2(WIN + 1);
    localparam int PIX_W      = 8;
    localparam int W_LIM      = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_LIM      = 1024;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef logic [PIX_W-1:0]            pix_t;
    typedef logic [SIDE-1:0][PIX_W-1:0]  column_t;
    typedef logic [WIN-1:0][PIX_W-1:0]   win_t;
    typedef logic [WIN-1:0]              alive_t;
    typedef logic [RANK_W-1:0]           rank_t;

    typedef struct packed {
        logic       valid;
        logic [9:0] row;
        logic [9:0] col;
        logic       done;
    } meta_t;

endpackage

`default_nettype wire

[sv/swmf_line_ram.sv]
// ============================================================================
// swmf_line_ram: one line of the line store
// Single write port, single read port with registered, read-first data.
// ============================================================================
`default_nettype none

module swmf_line_ram
    import swmf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire pix_t              wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output pix_t                   rdata
);

    pix_t mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/swmf_col_cell.sv]
// ============================================================================
// swmf_col_cell: one column of the window shift register
// Takes the column of its right neighbor each time a pixel moves in.
// ============================================================================
`default_nettype none

module swmf_col_cell
    import swmf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire column_t col_in,
    output column_t      col_out
);

    column_t col_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

[sv/swmf_radix_cell.sv]
// ============================================================================
// swmf_radix_cell: one bit of the radix rank select
// Decides one median bit from the top bit plane and narrows the candidates.
// ============================================================================
`default_nettype none

module swmf_radix_cell
    import swmf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire win_t   vals_in,
    input  wire alive_t alive_in,
    input  wire rank_t  rank_in,
    input  wire pix_t   med_in,
    output win_t        vals_out,
    output alive_t      alive_out,
    output rank_t       rank_out,
    output pix_t        med_out
);

    win_t   vals_reg;
    alive_t alive_reg;
    rank_t  rank_reg;
    pix_t   med_reg;

    alive_t zero_set;
    alive_t one_set;
    rank_t  zero_cnt;
    logic   bit_one;

    // Candidates whose current top bit is zero; the median bit is one when
    // the wanted rank lies beyond all of them.
    always_comb
    begin
        zero_cnt = '0;
        for (int i = 0; i < WIN; i++)
        begin
            zero_set[i] = alive_in[i] & ~vals_in[i][PIX_W-1];
            one_set[i]  = alive_in[i] &  vals_in[i][PIX_W-1];
            zero_cnt    = zero_cnt + rank_t'(zero_set[i]);
        end
        bit_one = (rank_in >= zero_cnt);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                vals_reg[i] <= {vals_in[i][PIX_W-2:0], 1'b0};
            end
            alive_reg <= bit_one ? one_set : zero_set;
            rank_reg  <= bit_one ? (rank_in - zero_cnt) : rank_in;
            med_reg   <= {med_in[PIX_W-2:0], bit_one};
        end
    end

    assign vals_out  = vals_reg;
    assign alive_out = alive_reg;
    assign rank_out  = rank_reg;
    assign med_out   = med_reg;

endmodule

`default_nettype wire

[sv/sliding_window_median_filter_unit.sv]
// ============================================================================
// sliding_window_median_filter_unit: streaming 2-D median filter
// Square window of side 2R+1 over raster pixels, median of interior points.
// ============================================================================
//
//  channel  | direction | signals                                   | handshake
//  ---------+-----------+-------------------------------------------+----------
//  pixel    | in        | pixel, frame_start                        | valid/ready
//  median   | out       | median_value, out_row, out_col, frame_done| valid/ready
//  config   | in        | cfg_we, cfg_index, cfg_data               | write only
//
// One pixel transfer is taken every clock unless the output stalls; the rate
// is set by the line RAMs, read and written once per pixel at the current column.
// After the edge that takes its pixel, a result is registered in turn by the
// window shift, the padding register and eight radix-select cells.
// Reset clears counters, stage valid flags and configuration to defaults;
// line and window contents are not cleared.
// A stalled median output holds the whole pipeline, and pixel_ready drops
// only while a result waits and median_ready is low.
// ============================================================================
`default_nettype none

module sliding_window_median_filter_unit
    import swmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        pixel_valid,
    output logic             pixel_ready,
    input  wire logic [7:0]  pixel,
    input  wire logic        frame_start,
    output logic             median_valid,
    input  wire logic        median_ready,
    output logic [7:0]       median_value,
    output logic [9:0]       out_row,
    output logic [9:0]       out_col,
    output logic             frame_done
);

    // Configuration registers.
    logic [1:0]  radius_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 2'd1;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // The whole pipeline moves when the output register is free or drained.
    logic adv;
    logic accept;
    meta_t out_meta;

    assign adv         = !out_meta.valid || median_ready;
    assign pixel_ready = adv;
    assign accept      = pixel_valid && adv;

    // Position counters. The slot counter tracks the row modulo the number
    // of lines so no divider is needed to pick the line RAM.
    logic [9:0]        row_count_reg, row_count_next;
    logic [9:0]        col_count_reg, col_count_next;
    logic [SLOT_W-1:0] row_slot_reg, row_slot_next;

    logic [10:0]       eff_w, eff_h;
    logic [9:0]        row_cur, col_cur;
    logic [SLOT_W-1:0] slot_cur;
    logic [10:0]       row_ext, col_ext, row_inc, col_inc, two_r;
    logic              emit, col_wrap, row_wrap, last_pix;

    always_comb
    begin
        if (width_reg == 11'd0)
            eff_w = 11'd1;
        else if (width_reg > 11'(W_LIM))
            eff_w = 11'(W_LIM);
        else
            eff_w = width_reg;

        if (height_reg == 11'd0)
            eff_h = 11'd1;
        else if (height_reg > 11'(H_LIM))
            eff_h = 11'(H_LIM);
        else
            eff_h = height_reg;

        row_cur  = frame_start ? 10'd0 : row_count_reg;
        col_cur  = frame_start ? 10'd0 : col_count_reg;
        slot_cur = frame_start ? '0 : row_slot_reg;

        row_ext  = {1'b0, row_cur};
        col_ext  = {1'b0, col_cur};
        row_inc  = row_ext + 11'd1;
        col_inc  = col_ext + 11'd1;
        two_r    = {8'd0, radius_reg, 1'b0};

        emit     = (row_ext < eff_h) && (col_ext < eff_w)
                   && (row_ext >= two_r) && (col_ext >= two_r);
        last_pix = (row_inc == eff_h) && (col_inc == eff_w);
        col_wrap = (col_inc >= eff_w);
        row_wrap = (row_inc >= eff_h);

        if (!col_wrap)
        begin
            col_count_next = col_inc[9:0];
            row_count_next = row_cur;
            row_slot_next  = slot_cur;
        end
        else if (row_wrap)
        begin
            col_count_next = 10'd0;
            row_count_next = 10'd0;
            row_slot_next  = '0;
        end
        else
        begin
            col_count_next = 10'd0;
            row_count_next = row_inc[9:0];
            row_slot_next  = (slot_cur == SLOT_W'(LINES - 1)) ? '0 : slot_cur + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            row_slot_reg  <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            row_slot_reg  <= row_slot_next;
        end
    end

    // Line store: one RAM per buffered line, all read at the current column
    // while the new pixel overwrites the oldest line.
    logic [LINES-1:0] ram_we;
    pix_t             ram_q [LINES];
    logic [ADDR_W-1:0] ram_addr;

    assign ram_addr = ADDR_W'(col_cur);

    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        assign ram_we[g] = accept && (slot_cur == SLOT_W'(g));

        swmf_line_ram u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_addr),
            .wdata (pixel),
            .re    (accept),
            .raddr (ram_addr),
            .rdata (ram_q[g])
        );
    end

    // Stage 1: the accepted pixel and its position wait for the RAM data.
    logic              s1_take_reg;
    meta_t             s1_meta_reg;
    pix_t              s1_pixel_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [1:0]        s1_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_take_reg <= 1'b0;
            s1_meta_reg <= '0;
        end
        else if (adv)
        begin
            s1_take_reg       <= accept;
            s1_meta_reg.valid <= accept && emit;
            s1_meta_reg.row   <= row_cur - {8'd0, radius_reg};
            s1_meta_reg.col   <= col_cur - {8'd0, radius_reg};
            s1_meta_reg.done  <= last_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pixel_reg  <= pixel;
            s1_slot_reg   <= slot_cur;
            s1_radius_reg <= radius_reg;
        end
    end

    // New window column: line d rows above sits in slot (slot - d) mod LINES.
    // Rows beyond the current window side load zero, as the window expects.
    column_t new_col;

    always_comb
    begin
        int idx;
        idx = 0;
        new_col[SIDE-1] = s1_pixel_reg;
        for (int d = 1; d <= LINES; d++)
        begin
            idx = int'(s1_slot_reg) + LINES - d;
            if (idx >= LINES)
                idx = idx - LINES;
            if (d <= 2 * int'(s1_radius_reg))
                new_col[SIDE-1-d] = ram_q[SLOT_W'(idx)];
            else
                new_col[SIDE-1-d] = '0;
        end
    end

    // Window: a chain of column cells shifting left once per pixel.
    column_t wcol [SIDE];
    logic    win_shift;

    assign win_shift = adv && s1_take_reg;

    for (genvar j = 0; j < SIDE; j++)
    begin : g_col
        column_t cin;
        if (j == SIDE - 1)
        begin : g_last
            assign cin = new_col;
        end
        else
        begin : g_mid
            assign cin = wcol[j+1];
        end

        swmf_col_cell u_cell (
            .clk     (clk),
            .en      (win_shift),
            .col_in  (cin),
            .col_out (wcol[j])
        );
    end

    // Stage 2: the window now holds the columns for this position.
    meta_t      s2_meta_reg;
    logic [1:0] s2_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_meta_reg <= '0;
        end
        else if (adv)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_radius_reg <= s1_radius_reg;
        end
    end

    // Padding: every position outside the active square gets 0 or 255 in
    // equal numbers, so the middle of all entries equals the middle of the
    // active square. Transposed pairs split one each way, and the diagonal
    // alternates.
    win_t padded;

    always_comb
    begin
        int first;
        first = SIDE - 1 - 2 * int'(s2_radius_reg);
        for (int i = 0; i < SIDE; i++)
        begin
            for (int j = 0; j < SIDE; j++)
            begin
                if (i >= first && j >= first)
                    padded[i*SIDE+j] = wcol[j][i];
                else if (i == j)
                    padded[i*SIDE+j] = (i % 2 == 0) ? 8'h00 : 8'hFF;
                else if (i < j)
                    padded[i*SIDE+j] = 8'h00;
                else
                    padded[i*SIDE+j] = 8'hFF;
            end
        end
    end

    // Stage 3 and the radix cells: one median bit per cell, MSB first.
    win_t   vals_chain  [PIX_W+1];
    alive_t alive_chain [PIX_W+1];
    rank_t  rank_chain  [PIX_W+1];
    pix_t   med_chain   [PIX_W+1];
    meta_t  meta_chain  [PIX_W+1];
    win_t   prep_vals_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_vals_reg <= padded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_chain[0] <= '0;
        end
        else if (adv)
        begin
            meta_chain[0] <= s2_meta_reg;
        end
    end

    assign vals_chain[0]  = prep_vals_reg;
    assign alive_chain[0] = '1;
    assign rank_chain[0]  = rank_t'(MID);
    assign med_chain[0]   = '0;

    for (genvar b = 0; b < PIX_W; b++)
    begin : g_radix
        swmf_radix_cell u_cell (
            .clk       (clk),
            .en        (adv),
            .vals_in   (vals_chain[b]),
            .alive_in  (alive_chain[b]),
            .rank_in   (rank_chain[b]),
            .med_in    (med_chain[b]),
            .vals_out  (vals_chain[b+1]),
            .alive_out (alive_chain[b+1]),
            .rank_out  (rank_chain[b+1]),
            .med_out   (med_chain[b+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                meta_chain[b+1] <= '0;
            end
            else if (adv)
            begin
                meta_chain[b+1] <= meta_chain[b];
            end
        end
    end

    // The last radix cell doubles as the output register.
    assign out_meta     = meta_chain[PIX_W];
    assign median_valid = out_meta.valid;
    assign median_value = med_chain[PIX_W];
    assign out_row      = out_meta.row;
    assign out_col      = out_meta.col;
    assign frame_done   = out_meta.done;

    // The slot counter must follow the row counter modulo the line count.
    a_slot_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
        row_slot_reg == SLOT_W'(row_count_reg % LINES))
        else $error("line slot out of step with row counter");

    // At most one line RAM takes the new pixel.
    a_one_line_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ram_we))
        else $error("more than one line RAM written");

    // The rank select always keeps at least one candidate for the median.
    a_candidate_left: assert property (@(posedge clk) disable iff (!rst_n)
        median_valid |-> (|alive_chain[PIX_W]))
        else $error("rank select lost all candidates");

endmodule

`default_nettype wire

[verif/median_window_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// median_window_checker: scoreboard for the sliding window median filter
// Tracks register writes and pixel transfers, computes the median each
// interior pixel should produce, and compares the result transfers in order.
// ============================================================================
`default_nettype none

module median_window_checker
    import swmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        pixel_valid,
    input  wire logic        pixel_ready,
    input  wire logic [7:0]  pixel,
    input  wire logic        frame_start,
    input  wire logic        median_valid,
    input  wire logic        median_ready,
    input  wire logic [7:0]  median_value,
    input  wire logic [9:0]  out_row,
    input  wire logic [9:0]  out_col,
    input  wire logic        frame_done,
    output int               pending,
    output int               fail_count
);

    typedef struct packed {
        pix_t       med;
        logic [9:0] row;
        logic [9:0] col;
        logic       done;
    } median_item_t;

    median_item_t expected_medians[$];

    pix_t        line_mem [LINES][MAX_WIDTH];
    pix_t        win_mem  [SIDE][SIDE];
    logic [9:0]  row_pos;
    logic [9:0]  col_pos;
    logic [1:0]  radius_q;
    logic [10:0] width_q;
    logic [10:0] height_q;

    function automatic pix_t window_median(input int r);
        pix_t v [SIDE*SIDE];
        pix_t x;
        int   n;
        int   first;
        int   j;
        n = 0;
        first = SIDE - 1 - 2 * r;
        for (int a = first; a < SIDE; a++)
            for (int b = first; b < SIDE; b++)
            begin
                v[n] = win_mem[a][b];
                n++;
            end
        for (int i = 1; i < n; i++)
        begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x)
            begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        return v[n/2];
    endfunction

    // Advances the filter state by one pixel and queues the result it causes.
    task automatic filter_pixel(input pix_t px, input logic fs);
        int w;
        int h;
        int r;
        int row;
        int col;
        int ci;
        int slot;
        median_item_t item;
        w = (width_q == 0) ? 1 : ((width_q > W_LIM) ? W_LIM : width_q);
        h = (height_q == 0) ? 1 : ((height_q > H_LIM) ? H_LIM : height_q);
        r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
        if (fs)
        begin
            row_pos = '0;
            col_pos = '0;
        end
        row = row_pos;
        col = col_pos;
        ci = col % MAX_WIDTH;
        for (int i = 0; i < SIDE; i++)
        begin
            for (int j = 0; j < SIDE - 1; j++)
                win_mem[i][j] = win_mem[i][j+1];
            win_mem[i][SIDE-1] = '0;
        end
        for (int d = 1; d <= 2 * r; d++)
        begin
            slot = (row + 2 * LINES - d) % LINES;
            win_mem[SIDE-1-d][SIDE-1] = line_mem[slot][ci];
        end
        win_mem[SIDE-1][SIDE-1] = px;
        line_mem[row % LINES][ci] = px;
        if (row < h && col < w && row >= 2 * r && col >= 2 * r)
        begin
            item.med  = window_median(r);
            item.row  = 10'(row - r);
            item.col  = 10'(col - r);
            item.done = (row == h - 1 && col == w - 1);
            expected_medians = {expected_medians, item};
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        row_pos = 10'(row);
        col_pos = 10'(col);
    endtask

    initial
    begin
        for (int i = 0; i < LINES; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
                line_mem[i][j] = '0;
        for (int i = 0; i < SIDE; i++)
            for (int j = 0; j < SIDE; j++)
                win_mem[i][j] = '0;
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos  = '0;
            col_pos  = '0;
            radius_q = 2'd1;
            width_q  = 11'd640;
            height_q = 11'd480;
            expected_medians.delete();
            pending  = 0;
        end
        else
        begin
            // A pixel taken at this edge still sees the old registers.
            if (pixel_valid && pixel_ready)
                filter_pixel(pixel, frame_start);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIUS: radius_q = cfg_data[1:0];
                    REG_WIDTH:  width_q  = cfg_data;
                    REG_HEIGHT: height_q = cfg_data;
                    default: ;
                endcase
            end
            if (median_valid && median_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    $error("unexpected median transfer row %0d col %0d", out_row, out_col);
                    fail_count++;
                end
                else
                begin
                    median_item_t e;
                    e = expected_medians.pop_front();
                    if (median_value !== e.med)
                    begin
                        $error("median_value expected %0d actual %0d", e.med, median_value);
                        fail_count++;
                    end
                    if (out_row !== e.row)
                    begin
                        $error("out_row expected %0d actual %0d", e.row, out_row);
                        fail_count++;
                    end
                    if (out_col !== e.col)
                    begin
                        $error("out_col expected %0d actual %0d", e.col, out_col);
                        fail_count++;
                    end
                    if (frame_done !== e.done)
                    begin
                        $error("frame_done expected %0d actual %0d", e.done, frame_done);
                        fail_count++;
                    end
                end
            end
            pending = expected_medians.size();
        end
    end

endmodule

`default_nettype wire

[verif/sliding_window_median_filter_unit_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// sliding_window_median_filter_unit_test: top of the median filter testbench
// Streams directed and random frames through the filter under several window
// and image sizes while a checker predicts every median and compares it.
// ============================================================================
`default_nettype none

module sliding_window_median_filter_unit_test;
    import swmf_pkg::*;

    // This many idle cycles lets any pixel that causes no result drain through
    // the pipeline before the registers change.
    localparam int DRAIN_CYCLES = 24;
    // Longest plain stretch without any transfer that a healthy run can show.
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    // Random frames start until this many pixels have gone in.
    localparam int ITEM_TARGET  = 850;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        pixel_valid;
    logic        pixel_ready;
    logic [7:0]  pixel;
    logic        frame_start;
    logic        median_valid;
    logic        median_ready;
    logic [7:0]  median_value;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic        frame_done;
    int          pending;
    int          fail_count;

    // Burst bookkeeping for the pixel sender and the hold-off request that
    // the result receiver serves in its own process.
    int          burst_left;
    int          pixels_sent;
    logic        hold_request;
    int          idle_cycles;

    sliding_window_median_filter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .median_valid (median_valid),
        .median_ready (median_ready),
        .median_value (median_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_done   (frame_done)
    );

    median_window_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .median_valid (median_valid),
        .median_ready (median_ready),
        .median_value (median_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_done   (frame_done),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: any cycle that moves a transfer on either channel restarts
    // the count, so a hung handshake ends the run.
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (median_valid && median_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result receiver. It mostly alternates between stretches of steady
    // acceptance and random stalls; when asked it refuses transfers for a
    // long stretch so that the pipeline fills and the input side backs up.
    initial
    begin
        int span;
        int mode;
        median_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                median_ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            span = $urandom_range(40, 1);
            mode = $urandom_range(3, 0);
            for (int i = 0; i < span && !hold_request; i++)
            begin
                if (mode == 0)
                    median_ready <= 1'b1;
                else if (mode == 1)
                    median_ready <= ($urandom_range(3, 0) != 0);
                else
                    median_ready <= $urandom_range(1, 0);
                @(posedge clk);
            end
        end
    end

    // Offers one pixel and returns right after the edge that takes it. Gaps
    // fall between bursts of random length.
    task automatic send_pixel(input logic [7:0] px, input logic fs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(30, 1);
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                for (int i = 0; i < gap; i++)
                    @(posedge clk);
            end
        end
        burst_left--;
        pixel_valid <= 1'b1;
        pixel       <= px;
        frame_start <= fs;
        do
            @(negedge clk);
        while (!pixel_ready);
        @(posedge clk);
        pixels_sent++;
    endtask

    // Stops offering pixels and waits until every queued median has come
    // back and the pipeline has drained the pixels that caused none.
    task automatic drain_pipeline();
        pixel_valid <= 1'b0;
        frame_start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < DRAIN_CYCLES; i++)
            @(posedge clk);
    endtask

    // Raises the write enable and waits for the edge that takes the write; the caller lowers it.
    task automatic write_register(input logic [1:0] idx, input logic [10:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int r, input int w, input int h);
        drain_pipeline();
        write_register(REG_RADIUS, 11'(r));
        write_register(REG_WIDTH,  11'(w));
        write_register(REG_HEIGHT, 11'(h));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Sends a frame of random pixels. A frame may be cut short; frame_start on the
    // first pixel, sent when mark_start is set, restarts the counters.
    task automatic send_frame(input int w, input int h, input logic mark_start,
                              input int cut_at);
        int total;
        total = w * h;
        if (cut_at > 0 && cut_at < total)
            total = cut_at;
        for (int i = 0; i < total; i++)
            send_pixel(8'($urandom), (i == 0) && mark_start);
    endtask

    initial
    begin
        int r;
        int w;
        int h;
        int frames;
        cfg_we       = 1'b0;
        cfg_index    = REG_RADIUS;
        cfg_data     = '0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        frame_start  = 1'b0;
        burst_left   = 0;
        pixels_sent  = 0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: a few pixels of row 0, which lie on the border.
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h5A, 1'b0);

        // Radius zero passes every pixel through; the frame wraps on its own
        // into a second frame without frame_start.
        set_geometry(0, 4, 3);
        for (int i = 0; i < 12; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, i == 0);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h5A, 1'b0);

        // Largest window exactly fills a 7x7 frame: one median, frame done.
        set_geometry(3, 7, 7);
        send_frame(7, 7, 1'b1, 0);

        // Zero sizes count as one pixel; each pixel is a complete frame.
        set_geometry(0, 0, 0);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b0);

        // Oversized width and height saturate; a long stretch of row 0 stays short
        // of the reset width. Every pixel gives a result, and the receiver
        // holds off for a long time meanwhile, so the input side backs up.
        set_geometry(0, 2047, 2047);
        hold_request = 1'b1;
        send_frame(1024, 1, 1'b1, 300);

        // Radius register written with its top value and a mid-size window.
        set_geometry(3, 9, 8);
        send_frame(9, 8, 1'b1, 0);
        set_geometry(2, 6, 5);
        send_frame(6, 5, 1'b1, 0);

        // Random geometries, mostly whole frames with occasional frames cut
        // short or started without frame_start.
        while (pixels_sent < ITEM_TARGET)
        begin
            r = $urandom_range(3, 0);
            w = $urandom_range(24, 2 * r + 1);
            h = $urandom_range(12, 2 * r + 1);
            if ($urandom_range(9, 0) == 0)
                w = $urandom_range(2 * r + 1, 0);
            set_geometry(r, w, h);
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames && pixels_sent < ITEM_TARGET; f++)
            begin
                if ($urandom_range(7, 0) == 0)
                    send_frame((w == 0) ? 1 : w, h, 1'b1,
                               $urandom_range(((w == 0) ? 1 : w) * h, 1));
                else
                    send_frame((w == 0) ? 1 : w, h, (f == 0) || $urandom_range(1, 0), 0);
            end
        end

        drain_pipeline();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
